@@ design/pnm_pkg.sv @@
package pnm_pkg;

	// payload widths
	localparam int OP_W    = 2;
	localparam int INDEX_W = 8;
	localparam int COMP_W  = 8;

	// r*(r+g+b) tops out at 255*765 = 195075
	localparam int KEY_W = 18;

	localparam int PALETTE_SIZE_DEFAULT = 256;

	// item opcodes; the fourth code is unused
	localparam logic [OP_W-1:0] OP_SET  = 2'd0;
	localparam logic [OP_W-1:0] OP_LOAD = 2'd1;
	localparam logic [OP_W-1:0] OP_USE  = 2'd2;

	typedef logic [KEY_W-1:0] key_t;

	function automatic key_t colour_key(
		input logic [COMP_W-1:0] r,
		input logic [COMP_W-1:0] g,
		input logic [COMP_W-1:0] b
	);
		logic [COMP_W+1:0] sum;
		logic [COMP_W+COMP_W+1:0] prod;
		sum  = {2'b00, r} + {2'b00, g} + {2'b00, b};
		prod = {{(COMP_W+2){1'b0}}, r} * {{COMP_W{1'b0}}, sum};
		return prod[KEY_W-1:0];
	endfunction

endpackage

@@ design/pnm_if.sv @@
interface pnm_cmd_if;
	logic                          valid;
	logic                          ready;
	logic [pnm_pkg::OP_W-1:0]      opcode;
	logic [pnm_pkg::INDEX_W-1:0]   palette_index;
	logic [pnm_pkg::COMP_W-1:0]    red;
	logic [pnm_pkg::COMP_W-1:0]    green;
	logic [pnm_pkg::COMP_W-1:0]    blue;

	modport source (output valid, opcode, palette_index, red, green, blue, input ready);
	modport sink   (input valid, opcode, palette_index, red, green, blue, output ready);
endinterface

interface pnm_res_if;
	logic                          valid;
	logic                          ready;
	logic [pnm_pkg::INDEX_W-1:0]   chosen_index;

	modport source (output valid, chosen_index, input ready);
	modport sink   (input valid, chosen_index, output ready);
endinterface

@@ design/palette_nearest_match.sv @@
// Nearest palette colour match. Holds a requested and an active palette of
// PALETTE_SIZE entries, stored as colour keys r*(r+g+b) in two single-port-
// write, registered-read memories. Set and load items write in the cycle of
// their transfer and give no result; an unused opcode is dropped. A use item
// with fixed_palette clear returns its own index. With fixed_palette set the
// block reads the requested key, then streams the active memory one entry per
// cycle through an absolute-difference compare, and no next item is taken
// until the result of the scan has been loaded into the output register. The
// earliest entry with the smallest difference wins and the result is the
// winner's index truncated to 8 bits. After reset a clearing pass zeroes both
// memories; no item is taken during it, configuration writes are. A result
// waits in the output register while the next item is taken. Configure only
// while idle.
module palette_nearest_match #(
	parameter int PALETTE_SIZE = pnm_pkg::PALETTE_SIZE_DEFAULT
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_wr_en,
	input  logic          cfg_wr_data,
	pnm_cmd_if.sink       cmd,
	pnm_res_if.source     res
);

	localparam int IdxW = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;
	// wide enough to compare an 8-bit index against the palette size
	localparam int CmpW = (IdxW + 1 > pnm_pkg::INDEX_W + 1) ? IdxW + 1 : pnm_pkg::INDEX_W + 1;
	localparam logic [IdxW-1:0] LastAddr = IdxW'(PALETTE_SIZE - 1);

	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_KEY   = 6'b000100,
		ST_SCAN  = 6'b001000,
		ST_DRAIN = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

	state_t state_q;

	// palettes, held as keys
	pnm_pkg::key_t req_mem [PALETTE_SIZE];
	pnm_pkg::key_t act_mem [PALETTE_SIZE];

	logic                          fixed_palette_q;
	logic [IdxW-1:0]               clr_addr_q;
	logic [IdxW-1:0]               scan_addr_q;
	logic                          in_range_q;
	pnm_pkg::key_t                 want_q;
	pnm_pkg::key_t                 req_rd_q;
	pnm_pkg::key_t                 act_rd_s1;
	logic [IdxW-1:0]               idx_s1;
	logic                          valid_s1;
	logic                          first_q;
	pnm_pkg::key_t                 best_diff_q;
	logic [IdxW-1:0]               best_idx_q;
	logic [pnm_pkg::INDEX_W-1:0]   result_q;
	logic                          res_valid_q;
	logic [pnm_pkg::INDEX_W-1:0]   res_index_q;

	logic            accept;
	logic            in_range;
	logic [IdxW-1:0] in_addr;
	pnm_pkg::key_t   in_key;
	logic            wr_act;
	logic            wr_req;
	logic [IdxW-1:0] wr_addr;
	pnm_pkg::key_t   wr_key;
	pnm_pkg::key_t   diff;
	logic            take;
	logic            res_load;

	assign cmd.ready = (state_q == ST_IDLE);
	assign accept    = cmd.valid & cmd.ready;

	// writes beyond the palette are dropped; a use beyond it reads key zero
	assign in_range = CmpW'(cmd.palette_index) < CmpW'(PALETTE_SIZE);
	assign in_addr  = IdxW'(cmd.palette_index);
	assign in_key   = pnm_pkg::colour_key(cmd.red, cmd.green, cmd.blue);

	// write port: clearing pass or a set/load transfer
	always_comb begin
		wr_act  = 1'b0;
		wr_req  = 1'b0;
		wr_addr = in_addr;
		wr_key  = in_key;
		if (state_q == ST_CLEAR) begin
			wr_act  = 1'b1;
			wr_req  = 1'b1;
			wr_addr = clr_addr_q;
			wr_key  = '0;
		end else if (accept && in_range) begin
			case (cmd.opcode)
				pnm_pkg::OP_SET: begin
					wr_act = 1'b1;
					wr_req = 1'b1;
				end
				pnm_pkg::OP_LOAD: wr_act = 1'b1;
				default: ;
			endcase
		end
	end

	// writes only happen while idle or clearing, reads only during a use,
	// so no same-entry overlap needs forwarding
	always_ff @(posedge clk) begin
		if (wr_req) begin
			req_mem[wr_addr] <= wr_key;
		end
		req_rd_q <= req_mem[in_addr];
	end

	always_ff @(posedge clk) begin
		if (wr_act) begin
			act_mem[wr_addr] <= wr_key;
		end
		act_rd_s1 <= act_mem[scan_addr_q];
	end

	assign diff = (act_rd_s1 > want_q) ? (act_rd_s1 - want_q) : (want_q - act_rd_s1);
	assign take = valid_s1 && (first_q || (diff < best_diff_q));

	// output register frees up as soon as its transfer is taken
	assign res_load = (state_q == ST_DONE) && (!res_valid_q || res.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fixed_palette_q <= 1'b0;
		end else if (cfg_wr_en) begin
			fixed_palette_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_addr_q  <= '0;
			scan_addr_q <= '0;
			valid_s1    <= 1'b0;
			first_q     <= 1'b0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == LastAddr) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept && (cmd.opcode == pnm_pkg::OP_USE)) begin
						state_q <= fixed_palette_q ? ST_KEY : ST_DONE;
					end
				end
				ST_KEY: begin
					// requested key is on the read port now
					scan_addr_q <= '0;
					first_q     <= 1'b1;
					state_q     <= ST_SCAN;
				end
				ST_SCAN: begin
					valid_s1    <= 1'b1;
					scan_addr_q <= scan_addr_q + 1'b1;
					if (take) begin
						first_q <= 1'b0;
					end
					if (scan_addr_q == LastAddr) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					valid_s1 <= 1'b0;
					if (take) begin
						first_q <= 1'b0;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (res_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_CLEAR;
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			in_range_q <= in_range;
			result_q   <= cmd.palette_index;
		end
		if (state_q == ST_KEY) begin
			want_q <= in_range_q ? req_rd_q : '0;
		end
		idx_s1 <= scan_addr_q;
		if (take) begin
			best_diff_q <= diff;
			best_idx_q  <= idx_s1;
		end
		if ((state_q == ST_DRAIN) && fixed_palette_q) begin
			result_q <= take ? pnm_pkg::INDEX_W'(idx_s1) : pnm_pkg::INDEX_W'(best_idx_q);
		end
		if (res_load) begin
			res_index_q <= result_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	assign res.valid        = res_valid_q;
	assign res.chosen_index = res_index_q;

endmodule

@@ tb/sv/pnm_checker.sv @@
// Watches both channels of the palette matcher, keeps its own copy of the two
// palettes and of the fixed-palette bit, and compares every result transfer
// with the oldest predicted index.
module pnm_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_wr_en,
	input  logic cfg_wr_data,
	pnm_cmd_if   cmd,
	pnm_res_if   res,
	output int   failures,
	output int   outstanding
);
	import pnm_pkg::*;

	localparam int          ENTRIES      = PALETTE_SIZE_DEFAULT;
	localparam int unsigned NO_MATCH_YET = 256 * 256 * 256;

	logic [3*COMP_W-1:0] requested_rgb [ENTRIES];
	logic [3*COMP_W-1:0] active_rgb [ENTRIES];
	logic                fixed_mode;
	logic [INDEX_W-1:0]  pending_choices [$];
	int                  fail_count = 0;
	int                  pending_count = 0;

	assign failures    = fail_count;
	assign outstanding = pending_count;

	function automatic int unsigned colour_weight(logic [3*COMP_W-1:0] rgb);
		int unsigned r, g, b;
		r = rgb[23:16];
		g = rgb[15:8];
		b = rgb[7:0];
		return r * (r + g + b);
	endfunction

	// first entry with the smallest weight gap wins
	function automatic logic [INDEX_W-1:0] nearest_entry(logic [INDEX_W-1:0] idx);
		int unsigned want, k, gap, best_gap;
		logic [INDEX_W-1:0] best;
		want     = colour_weight(requested_rgb[idx]);
		best     = idx;
		best_gap = NO_MATCH_YET;
		for (int i = 0; i < ENTRIES; i++) begin
			k   = colour_weight(active_rgb[i]);
			gap = (k > want) ? k - want : want - k;
			if (gap < best_gap) begin
				best_gap = gap;
				best     = INDEX_W'(i);
			end
		end
		return best;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [INDEX_W-1:0] want;
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) begin
				requested_rgb[i] = '0;
				active_rgb[i]    = '0;
			end
			fixed_mode = 1'b0;
			pending_choices.delete();
			pending_count = 0;
		end else begin
			if (cfg_wr_en)
				fixed_mode = cfg_wr_data;
			if (res.valid && res.ready) begin
				if (pending_choices.size() == 0) begin
					$error("chosen_index: expected none, actual %0d", res.chosen_index);
					fail_count++;
				end else begin
					want = pending_choices.pop_front();
					if (res.chosen_index !== want) begin
						$error("chosen_index: expected %0d, actual %0d", want, res.chosen_index);
						fail_count++;
					end
				end
			end
			if (cmd.valid && cmd.ready) begin
				case (cmd.opcode)
					OP_SET: begin
						active_rgb[cmd.palette_index]    = {cmd.red, cmd.green, cmd.blue};
						requested_rgb[cmd.palette_index] = {cmd.red, cmd.green, cmd.blue};
					end
					OP_LOAD: begin
						active_rgb[cmd.palette_index] = {cmd.red, cmd.green, cmd.blue};
					end
					OP_USE: begin
						if (fixed_mode)
							pending_choices.push_back(nearest_entry(cmd.palette_index));
						else
							pending_choices.push_back(cmd.palette_index);
					end
					default: ;
				endcase
			end
			pending_count = pending_choices.size();
		end
	end

endmodule

@@ tb/sv/testbench.sv @@
// Stimulus and verdict for palette_nearest_match. The checker beside the
// block does all prediction; this module only drives transfers, shapes the
// idling on both sides and reports the outcome.
module testbench;
	import pnm_pkg::*;

	// the fourth opcode, which the block must drop
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	localparam int IDLE_PCT    = 22;
	localparam int HOLD_CYCLES = 300;  // long enough to back the block up
	localparam int SETTLE      = 8;    // writes land on transfer

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic cfg_wr_data = 1'b0;

	pnm_cmd_if cmd_ch ();
	pnm_res_if res_ch ();

	int  failures;
	int  outstanding;
	bit  quiet = 1'b0;       // both sides stop idling while set
	int  holds_asked = 0;
	int  holds_done = 0;
	int  stall_left = 0;

	palette_nearest_match u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cmd         (cmd_ch.sink),
		.res         (res_ch.source)
	);

	pnm_checker u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cmd         (cmd_ch),
		.res         (res_ch),
		.failures    (failures),
		.outstanding (outstanding)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Hard stop, reported as a mismatch.
	initial begin
		#2000000;
		$display("palette_nearest_match: mismatch");
		$finish;
	end

	// Result side: random back-pressure, plus the long hold-offs the stimulus
	// asks for, counted out here a cycle at a time.
	initial begin
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				res_ch.ready = 1'b0;
				stall_left--;
			end else if (holds_done != holds_asked) begin
				holds_done++;
				stall_left   = HOLD_CYCLES - 1;
				res_ch.ready = 1'b0;
			end else begin
				res_ch.ready = quiet || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	// One transfer on the command side. Idle gaps go in front of the item;
	// valid stays high from one item to the next when no gap is drawn.
	task automatic send_item(input logic [OP_W-1:0] op, input logic [INDEX_W-1:0] idx,
			input logic [COMP_W-1:0] r, input logic [COMP_W-1:0] g,
			input logic [COMP_W-1:0] b);
		@(negedge clk);
		while (!quiet && $urandom_range(99) < IDLE_PCT) begin
			cmd_ch.valid = 1'b0;
			@(negedge clk);
		end
		cmd_ch.valid         = 1'b1;
		cmd_ch.opcode        = op;
		cmd_ch.palette_index = idx;
		cmd_ch.red           = r;
		cmd_ch.green         = g;
		cmd_ch.blue          = b;
		do @(posedge clk); while (!cmd_ch.ready);
	endtask

	// Drop valid, then wait until every predicted index has come back and the
	// block has had time to finish anything in flight.
	task automatic drain_results();
		@(negedge clk);
		cmd_ch.valid = 1'b0;
		wait (outstanding == 0);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_fixed(input logic value);
		@(negedge clk);
		cfg_wr_en   = 1'b1;
		cfg_wr_data = value;
		@(negedge clk);
		cfg_wr_en   = 1'b0;
	endtask

	// Colour mix: fully random, tiny components (plenty of equal weights, so
	// the first-minimum rule gets exercised), the corners, and a tight band.
	function automatic logic [3*COMP_W-1:0] random_colour();
		int style;
		style = $urandom_range(99);
		if (style < 40)
			return 24'($urandom);
		else if (style < 70)
			return {8'($urandom_range(3)), 8'($urandom_range(3)), 8'($urandom_range(3))};
		else if (style < 85)
			return {{8{1'($urandom)}}, {8{1'($urandom)}}, {8{1'($urandom)}}};
		else
			return {8'($urandom_range(100, 110)), 8'($urandom_range(90, 120)),
				8'($urandom_range(90, 120))};
	endfunction

	// Mostly writes and uses; half of them on a small index window so that uses
	// hit entries that were written, the rest anywhere in the palette.
	task automatic random_item();
		int                  roll;
		logic [OP_W-1:0]     op;
		logic [INDEX_W-1:0]  idx;
		logic [3*COMP_W-1:0] rgb;
		roll = $urandom_range(99);
		if (roll < 38)
			op = OP_SET;
		else if (roll < 58)
			op = OP_LOAD;
		else if (roll < 95)
			op = OP_USE;
		else
			op = OP_UNUSED;
		idx = $urandom_range(1) ? 8'($urandom_range(15)) : 8'($urandom);
		rgb = random_colour();
		send_item(op, idx, rgb[23:16], rgb[15:8], rgb[7:0]);
	endtask

	initial begin
		cmd_ch.valid         = 1'b0;
		cmd_ch.opcode        = OP_SET;
		cmd_ch.palette_index = '0;
		cmd_ch.red           = '0;
		cmd_ch.green         = '0;
		cmd_ch.blue          = '0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// Pass-through mode first; the block is still clearing, which only
		// holds back the first transfer.
		write_fixed(1'b0);
		send_item(OP_USE, 8'd0, 8'hff, 8'hff, 8'hff);
		send_item(OP_USE, 8'd255, 8'h00, 8'h00, 8'h00);
		send_item(OP_USE, 8'haa, 8'h55, 8'haa, 8'h55);
		send_item(OP_UNUSED, 8'hff, 8'hff, 8'hff, 8'hff);
		send_item(OP_SET, 8'd0, 8'h00, 8'h00, 8'h00);
		send_item(OP_SET, 8'd255, 8'hff, 8'hff, 8'hff);
		send_item(OP_SET, 8'd1, 8'hff, 8'h00, 8'h00);
		send_item(OP_LOAD, 8'd2, 8'hff, 8'hff, 8'hff);
		send_item(OP_SET, 8'd3, 8'h10, 8'h20, 8'h30);
		send_item(OP_LOAD, 8'd3, 8'hff, 8'hff, 8'hff);  // active now differs
		send_item(OP_SET, 8'd4, 8'h01, 8'h01, 8'h01);
		send_item(OP_USE, 8'd3, 8'h00, 8'h00, 8'h00);
		drain_results();

		// Search mode on the hand-built palette: an exact weight tie won by a
		// load-only entry, a zero request, an entry whose requested and active
		// colours disagree, an entry never written, a dropped opcode.
		write_fixed(1'b1);
		send_item(OP_USE, 8'd255, 8'h00, 8'h00, 8'h00);
		send_item(OP_USE, 8'd0, 8'hff, 8'hff, 8'hff);
		send_item(OP_USE, 8'd3, 8'h00, 8'h00, 8'h00);
		send_item(OP_USE, 8'd1, 8'h00, 8'h00, 8'h00);
		send_item(OP_USE, 8'd200, 8'h00, 8'h00, 8'h00);
		send_item(OP_UNUSED, 8'd0, 8'h00, 8'h00, 8'h00);
		send_item(OP_SET, 8'd0, 8'h0a, 8'h0b, 8'h0c);
		send_item(OP_USE, 8'd0, 8'h00, 8'h00, 8'h00);
		send_item(OP_USE, 8'd7, 8'h00, 8'h00, 8'h00);
		send_item(OP_LOAD, 8'd255, 8'h00, 8'h00, 8'h00);
		send_item(OP_USE, 8'd255, 8'h00, 8'h00, 8'h00);
		drain_results();

		// Random, search mode. A stretch with no idling, one pause until
		// everything is back, and one long hold-off on the result side.
		for (int n = 0; n < 450; n++) begin
			quiet = (n >= 100 && n < 200);
			if (n == 250) begin
				@(negedge clk);
				cmd_ch.valid = 1'b0;
				wait (outstanding == 0);
			end
			if (n == 350)
				holds_asked++;
			random_item();
		end
		quiet = 1'b0;
		drain_results();

		// Random, pass-through. Results are quick here, so the hold-off backs
		// the block up and it must refuse transfers until released.
		write_fixed(1'b0);
		for (int n = 0; n < 350; n++) begin
			quiet = (n >= 200 && n < 300);
			if (n == 50)
				holds_asked++;
			random_item();
		end
		quiet = 1'b0;
		drain_results();

		write_fixed(1'b1);
		for (int n = 0; n < 330; n++)
			random_item();

		// Everything is back; leave room for a stray result to show up.
		drain_results();
		repeat (20) @(negedge clk);
		if (failures == 0)
			$display("palette_nearest_match: match");
		else
			$display("palette_nearest_match: mismatch");
		$finish;
	end

endmodule
